// ===== design/motion_direction_detector_core_macros.svh =====
// Assertion macros used by the motion direction detector core.
// Each macro takes a label, the clock and the active low reset first.
`ifndef MOTION_DIRECTION_DETECTOR_CORE_MACROS_SVH
`define MOTION_DIRECTION_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define MDD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define MDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// The expression must hold at every clock edge out of reset.
`define MDD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

`else

`define MDD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define MDD_ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

// ===== design/mdd_pkg.sv =====
package mdd_pkg;

    localparam int ACCEL_W     = 16;
    localparam int RATE_W      = 12;
    localparam int TIME_W      = 32;
    localparam int DIR_W       = 3;
    localparam int THRESH_W    = 22;
    localparam int ENERGY_W    = 24;
    localparam int HOLD_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int SQUARE_W    = 23;

    localparam int WINDOW_DEFAULT = 20;

    localparam logic [THRESH_W-1:0] MOTION_THRESHOLD_RESET = THRESH_W'(1500);
    localparam logic [ENERGY_W-1:0] ENERGY_LIMIT_RESET     = ENERGY_W'(3600);
    localparam logic [HOLD_W-1:0]   HOLD_MS_RESET          = HOLD_W'(200);

    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_LIMIT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MS          = 2'd2;

    localparam logic [DIR_W-1:0] MOVE_NONE    = 3'd0;
    localparam logic [DIR_W-1:0] MOVE_RIGHT   = 3'd1;
    localparam logic [DIR_W-1:0] MOVE_LEFT    = 3'd2;
    localparam logic [DIR_W-1:0] MOVE_UP      = 3'd3;
    localparam logic [DIR_W-1:0] MOVE_DOWN    = 3'd4;
    localparam logic [DIR_W-1:0] MOVE_BACK    = 3'd5;
    localparam logic [DIR_W-1:0] MOVE_FORWARD = 3'd6;

    // One accelerometer triple, as held in each cell of the window.
    typedef struct packed {
        logic signed [ACCEL_W-1:0] x;
        logic signed [ACCEL_W-1:0] y;
        logic signed [ACCEL_W-1:0] z;
    } sample_t;

    // Control of the per-axis accumulators.
    typedef struct packed {
        logic clear;
        logic acc_en;
    } acc_ctrl_t;

endpackage

// ===== design/mdd_if.sv =====
interface mdd_sample_if import mdd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_y;
    logic signed [RATE_W-1:0]  rate_z;
    logic [TIME_W-1:0]         time_ms;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_ms,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_ms,
        output ready
    );
endinterface

interface mdd_result_if import mdd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] direction;
    logic             rotation_freeze;

    modport source (output valid, direction, rotation_freeze, input ready);
    modport sink (input valid, direction, rotation_freeze, output ready);
endinterface

interface mdd_cfg_if import mdd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/mdd_cell.sv =====
// One stage of the sample window: takes its neighbour's sample on a shift.
module mdd_cell import mdd_pkg::*; (
    input  logic    clk,
    input  logic    shift_en,
    input  sample_t d,
    output sample_t q
);

    sample_t sample_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= d;
        end
    end

    assign q = sample_reg;

endmodule

// ===== design/mdd_axis_acc.sv =====
// Sums absolute differences of one axis as the window rotates past the tail,
// and notes whether the newest sample exceeds the oldest.
module mdd_axis_acc import mdd_pkg::*; #(
    parameter int ACC_W = 21
) (
    input  logic                      clk,
    input  acc_ctrl_t                 ctrl,
    input  logic signed [ACCEL_W-1:0] tail,
    input  logic signed [ACCEL_W-1:0] tail_prev,
    input  logic signed [ACCEL_W-1:0] newest,
    input  logic signed [ACCEL_W-1:0] oldest,
    output logic [ACC_W-1:0]          sum,
    output logic                      net_pos
);

    logic [ACC_W-1:0]        sum_reg;
    logic                    net_pos_reg;
    logic signed [ACCEL_W:0] diff;
    logic signed [ACCEL_W:0] net;
    logic [ACCEL_W-1:0]      abs_diff;

    always_comb
    begin
        diff     = {tail[ACCEL_W-1], tail} - {tail_prev[ACCEL_W-1], tail_prev};
        net      = {newest[ACCEL_W-1], newest} - {oldest[ACCEL_W-1], oldest};
        abs_diff = diff[ACCEL_W] ? ACCEL_W'(-diff) : diff[ACCEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            sum_reg     <= '0;
            net_pos_reg <= (net > 0);
        end
        else if (ctrl.acc_en)
        begin
            sum_reg <= sum_reg + ACC_W'(abs_diff);
        end
    end

    assign sum     = sum_reg;
    assign net_pos = net_pos_reg;

endmodule

// ===== design/motion_direction_detector_core.sv =====
// Motion direction detector.
// Each sample item carries three accelerometer readings, three gyro rates and a
// millisecond tick; each accepted item yields exactly one result item with a
// direction code and a rotation freeze flag. Configuration writes go through a
// separate channel that is always ready and must only be used while idle.
// Items are handled one at a time. A warm-up item (the first WINDOW after reset)
// goes straight from ST_IDLE to ST_EMIT. An item cut short by rotation passes
// through ST_SQUARE and ST_ENERGY to ST_EMIT. A detecting item also passes
// through ST_SCAN and ST_JUDGE, since in ST_SCAN the window of cells rotates
// once fully past the difference accumulators, one cell per cycle; the default
// window holds 20 samples.
// The sample side is ready again as soon as the result is loaded, so a new item
// can be taken while the previous result still waits to be collected.
// If the receiver stalls, the finished result waits in the output register and
// the block holds the next result back until the register is free.
// Reset clears the fill count, the freeze state and the output register and
// restores the configuration defaults; the window contents need no clearing
// because nothing is judged before the window has been filled.
`include "motion_direction_detector_core_macros.svh"

module motion_direction_detector_core import mdd_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    mdd_sample_if.sink   sample_ch,
    mdd_result_if.source result_ch,
    mdd_cfg_if.sink      cfg_ch
);

    localparam int ACC_W  = ACCEL_W + $clog2(WINDOW);
    localparam int TOT_W  = ACC_W + 2;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int CNT_W  = $clog2(WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ENERGY,
        ST_SCAN,
        ST_JUDGE,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [THRESH_W-1:0] motion_threshold_reg;
    logic [ENERGY_W-1:0] energy_limit_reg;
    logic [HOLD_W-1:0]   hold_ms_reg;

    // Control state.
    logic [FILL_W-1:0] fill_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic              frozen_reg;
    logic [TIME_W-1:0] frozen_since_reg;
    logic [DIR_W-1:0]  res_dir_reg;
    logic              res_freeze_reg;
    logic              out_valid_reg;
    logic [DIR_W-1:0]  out_dir_reg;
    logic              out_freeze_reg;

    // Per-item payload.
    logic signed [RATE_W-1:0] rate_x_reg;
    logic signed [RATE_W-1:0] rate_y_reg;
    logic signed [RATE_W-1:0] rate_z_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [SQUARE_W-1:0]      sq_x_reg;
    logic [SQUARE_W-1:0]      sq_y_reg;
    logic [SQUARE_W-1:0]      sq_z_reg;

    logic accept;
    logic shift_en;
    logic scan_last;
    logic out_load;

    sample_t new_sample;
    sample_t chain_d [WINDOW];
    sample_t chain_q [WINDOW];

    acc_ctrl_t        acc_ctrl;
    logic [ACC_W-1:0] sum_x;
    logic [ACC_W-1:0] sum_y;
    logic [ACC_W-1:0] sum_z;
    logic             pos_x;
    logic             pos_y;
    logic             pos_z;

    logic signed [2*RATE_W-1:0] prod_x;
    logic signed [2*RATE_W-1:0] prod_y;
    logic signed [2*RATE_W-1:0] prod_z;
    logic [ENERGY_W:0]          energy;
    logic [TIME_W-1:0]          elapsed;
    logic [TOT_W-1:0]           total;
    logic [DIR_W-1:0]           judged_dir;

    assign accept          = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign cfg_ch.ready    = 1'b1;

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.direction       = out_dir_reg;
    assign result_ch.rotation_freeze = out_freeze_reg;

    // The finished result moves into the output register once that is free or
    // is being emptied in the same cycle.
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || result_ch.ready);

    assign new_sample = '{x: sample_ch.accel_x, y: sample_ch.accel_y, z: sample_ch.accel_z};

    // The window is a chain of cells, newest at the head and oldest at the tail.
    // A new item shifts its sample in at the head; during the scan the tail is
    // fed back to the head, so after WINDOW shifts the chain is back in order.
    assign shift_en  = accept || (state_reg == ST_SCAN);
    assign scan_last = (scan_cnt_reg == CNT_W'(WINDOW - 1));

    always_comb
    begin
        chain_d[0] = (state_reg == ST_SCAN) ? chain_q[WINDOW-1] : new_sample;
        for (int i = 1; i < WINDOW; i++)
        begin
            chain_d[i] = chain_q[i-1];
        end
    end

    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        mdd_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .d        (chain_d[g]),
            .q        (chain_q[g])
        );
    end

    // The tail pair is consecutive in time on every scan step but the last,
    // where it would straddle newest and oldest; that step only restores order.
    assign acc_ctrl.clear  = (state_reg == ST_ENERGY);
    assign acc_ctrl.acc_en = (state_reg == ST_SCAN) && !scan_last;

    mdd_axis_acc #(.ACC_W(ACC_W)) u_acc_x (
        .clk       (clk),
        .ctrl      (acc_ctrl),
        .tail      (chain_q[WINDOW-1].x),
        .tail_prev (chain_q[WINDOW-2].x),
        .newest    (chain_q[0].x),
        .oldest    (chain_q[WINDOW-1].x),
        .sum       (sum_x),
        .net_pos   (pos_x)
    );

    mdd_axis_acc #(.ACC_W(ACC_W)) u_acc_y (
        .clk       (clk),
        .ctrl      (acc_ctrl),
        .tail      (chain_q[WINDOW-1].y),
        .tail_prev (chain_q[WINDOW-2].y),
        .newest    (chain_q[0].y),
        .oldest    (chain_q[WINDOW-1].y),
        .sum       (sum_y),
        .net_pos   (pos_y)
    );

    mdd_axis_acc #(.ACC_W(ACC_W)) u_acc_z (
        .clk       (clk),
        .ctrl      (acc_ctrl),
        .tail      (chain_q[WINDOW-1].z),
        .tail_prev (chain_q[WINDOW-2].z),
        .newest    (chain_q[0].z),
        .oldest    (chain_q[WINDOW-1].z),
        .sum       (sum_z),
        .net_pos   (pos_z)
    );

    // Gyro energy: three squares registered, then summed and compared.
    always_comb
    begin
        prod_x  = rate_x_reg * rate_x_reg;
        prod_y  = rate_y_reg * rate_y_reg;
        prod_z  = rate_z_reg * rate_z_reg;
        energy  = (ENERGY_W + 1)'(sq_x_reg) + (ENERGY_W + 1)'(sq_y_reg)
                + (ENERGY_W + 1)'(sq_z_reg);
        elapsed = now_reg - frozen_since_reg;
        total   = TOT_W'(sum_x) + TOT_W'(sum_y) + TOT_W'(sum_z);
    end

    // A direction is only given when the total reaches the motion threshold and one
    // axis is strictly dominant. A net change of zero on that axis counts as the negative direction.
    always_comb
    begin
        judged_dir = MOVE_NONE;
        if (32'(total) >= 32'(motion_threshold_reg))
        begin
            if (sum_x > sum_y && sum_x > sum_z)
            begin
                judged_dir = pos_x ? MOVE_RIGHT : MOVE_LEFT;
            end
            else if (sum_y > sum_x && sum_y > sum_z)
            begin
                judged_dir = pos_y ? MOVE_UP : MOVE_DOWN;
            end
            else if (sum_z > sum_x && sum_z > sum_y)
            begin
                judged_dir = pos_z ? MOVE_BACK : MOVE_FORWARD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rate_x_reg <= sample_ch.rate_x;
            rate_y_reg <= sample_ch.rate_y;
            rate_z_reg <= sample_ch.rate_z;
            now_reg    <= sample_ch.time_ms;
        end
        if (state_reg == ST_SQUARE)
        begin
            sq_x_reg <= prod_x[SQUARE_W-1:0];
            sq_y_reg <= prod_y[SQUARE_W-1:0];
            sq_z_reg <= prod_z[SQUARE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            motion_threshold_reg <= MOTION_THRESHOLD_RESET;
            energy_limit_reg     <= ENERGY_LIMIT_RESET;
            hold_ms_reg          <= HOLD_MS_RESET;
            fill_reg             <= '0;
            scan_cnt_reg         <= '0;
            frozen_reg           <= 1'b0;
            frozen_since_reg     <= '0;
            res_dir_reg          <= MOVE_NONE;
            res_freeze_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
            out_dir_reg          <= MOVE_NONE;
            out_freeze_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.index)
                    CFG_MOTION_THRESHOLD: motion_threshold_reg <= cfg_ch.data[THRESH_W-1:0];
                    CFG_ENERGY_LIMIT:     energy_limit_reg     <= cfg_ch.data[ENERGY_W-1:0];
                    CFG_HOLD_MS:          hold_ms_reg          <= cfg_ch.data[HOLD_W-1:0];
                    default:              ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_dir_reg    <= res_dir_reg;
                out_freeze_reg <= res_freeze_reg;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_dir_reg    <= MOVE_NONE;
                        res_freeze_reg <= 1'b0;
                        if (fill_reg < FILL_W'(WINDOW))
                        begin
                            // Warm-up: the sample is stored and nothing is judged.
                            fill_reg  <= fill_reg + FILL_W'(1);
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE:
                begin
                    state_reg <= ST_ENERGY;
                end
                ST_ENERGY:
                begin
                    scan_cnt_reg <= '0;
                    if (energy > (ENERGY_W + 1)'(energy_limit_reg))
                    begin
                        if (!frozen_reg)
                        begin
                            frozen_reg       <= 1'b1;
                            frozen_since_reg <= now_reg;
                        end
                        res_freeze_reg <= 1'b1;
                        state_reg      <= ST_EMIT;
                    end
                    else if (frozen_reg && elapsed <= TIME_W'(hold_ms_reg))
                    begin
                        res_freeze_reg <= 1'b1;
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        // Hold expired (or never frozen): detect in this item.
                        frozen_reg <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    if (scan_last)
                    begin
                        state_reg <= ST_JUDGE;
                    end
                end
                ST_JUDGE:
                begin
                    res_dir_reg <= judged_dir;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A frozen result never carries a direction.
    `MDD_ASSERT_IMPLIES(a_freeze_no_dir, clk, rst_n, out_valid_reg && out_freeze_reg,
        out_dir_reg == MOVE_NONE)
    // Only one item is in work at a time.
    `MDD_ASSERT_NEXT(a_one_item, clk, rst_n, accept, !sample_ch.ready)
    // The fill count saturates at the window length.
    `MDD_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= FILL_W'(WINDOW))
    // The freeze can only start from the energy decision.
    `MDD_ASSERT_IMPLIES(a_freeze_source, clk, rst_n, $rose(frozen_reg),
        $past(state_reg) == ST_ENERGY)

endmodule
